/* hw/rtl/assert_macros.svh */
// Assertion macros used by the top-level RTL file.
// Each macro samples on i_clk and is disabled while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define GWW_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define GWW_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/gww_pkg.sv */
// Shared types and constants of the greedy word wrap stream block.
// No dependencies.
package gww_pkg;

    typedef struct packed {
        logic [7:0] in_char;
        logic       end_of_text;
    } t_in_word;

    typedef struct packed {
        logic [7:0] out_char;
        logic       run_last;
    } t_out_word;

    localparam logic [7:0]  CH_SPACE    = 8'd32;
    localparam logic [7:0]  CH_NEWLINE  = 8'd10;
    localparam logic [7:0]  LIMIT_RESET = 8'd80;
    localparam logic [15:0] COLUMN_MAX  = 16'hFFFF;

endpackage

/* hw/rtl/greedy_word_wrap_stream_top.sv */
// Greedy word wrap stream, top level.
// Depends on gww_pkg, gww_word_buf and assert_macros.svh.
//
// Usage:
//   Input channel i_in_valid / o_in_ready carries one character word
//   (in_char, end_of_text). Output channel o_out_valid / i_out_ready carries
//   the wrapped text, one character word per handshake; run_last marks the
//   last output word caused by an input word. An input word may cause none.
//   i_cfg_we / i_cfg_wdata write the line limit; write only while idle.
//   One input word at a time: o_in_ready is high only in the idle state.
//   After acceptance ST_EVAL evaluates the word with an adder and
//   compare (column + word length + spaces against the limit), ST_NEXT
//   dispatches each output phase, then each space and newline is loaded
//   in ST_SP or ST_NL and each word character passes ST_RD and ST_WO
//   (store read, then output load); the load states wait while the output
//   register holds a word that is not taken. An input word with no output
//   goes back to idle from ST_NEXT.
//   The output register lets the next input be accepted while the last
//   result still waits; a stalled receiver holds the sequencer.
//   Reset clears the column, counts and output valid, and sets the limit
//   to 80; the word store is not cleared.
module greedy_word_wrap_stream_top #(
    parameter int BUF_DEPTH = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  gww_pkg::t_in_word i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output gww_pkg::t_out_word o_out_data,
    input  logic              i_cfg_we,
    input  logic [7:0]        i_cfg_wdata
);

    localparam int AW = $clog2(BUF_DEPTH);
    localparam int LW = AW + 1;
    localparam logic [AW-1:0] CAP = AW'(BUF_DEPTH - 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_EVAL = 3'd1;
    localparam logic [2:0] ST_NEXT = 3'd2;
    localparam logic [2:0] ST_SP   = 3'd3;
    localparam logic [2:0] ST_RD   = 3'd4;
    localparam logic [2:0] ST_WO   = 3'd5;
    localparam logic [2:0] ST_NL   = 3'd6;

    logic [2:0]         r_state, n_state;
    logic [7:0]         r_limit;
    logic [15:0]        r_col, n_col;
    logic [AW-1:0]      r_wl, n_wl;
    logic [AW-1:0]      r_sc, n_sc;
    logic [7:0]         r_ch, n_ch;
    logic               r_last, n_last;
    logic [AW-1:0]      r_sp, n_sp;
    logic               r_wpre, n_wpre;
    logic               r_wpost, n_wpost;
    logic               r_nl, n_nl;
    logic [AW-1:0]      r_idx, n_idx;
    logic [LW-1:0]      r_left, n_left;
    logic               r_ovalid, n_ovalid;
    gww_pkg::t_out_word r_out, n_out;

    logic          is_sp, is_nl, is_let, wl_room, commit_sp, word_pre, word_on, ins, gt;
    logic [AW-1:0] wl_eff, sp_emit;
    logic [16:0]   sum;
    logic [15:0]   col_sat;
    logic          slot_free, buf_we, buf_re;
    logic [7:0]    rdata;

    assign slot_free = !r_ovalid || i_out_ready;

    assign is_sp     = (r_ch == gww_pkg::CH_SPACE);
    assign is_nl     = (r_ch == gww_pkg::CH_NEWLINE);
    assign is_let    = !is_sp && !is_nl;
    assign wl_room   = (r_wl != CAP);
    assign wl_eff    = (is_let && wl_room) ? r_wl + AW'(1) : r_wl;
    assign sum       = {1'b0, r_col} + 17'(wl_eff) + 17'(r_sc);
    assign gt        = (sum > {9'd0, r_limit});
    assign col_sat   = sum[16] ? gww_pkg::COLUMN_MAX : sum[15:0];
    assign commit_sp = is_sp && (r_wl != '0 || r_sc == '0);
    assign word_pre  = commit_sp || (is_nl && r_wl != '0);
    assign word_on   = word_pre || r_last;
    assign ins       = is_let && gt && (8'(wl_eff) < r_limit);
    assign sp_emit   = (commit_sp || (is_nl && (r_wl != '0 || !gt))) ? r_sc : '0;

    assign buf_we = (r_state == ST_EVAL) && is_let && wl_room;
    assign buf_re = (r_state == ST_RD);

    gww_word_buf #(
        .BUF_DEPTH (BUF_DEPTH),
        .AW        (AW)
    ) u_word_buf (
        .i_clk   (i_clk),
        .i_we    (buf_we),
        .i_waddr (r_wl),
        .i_wdata (r_ch),
        .i_re    (buf_re),
        .i_raddr (r_idx),
        .o_rdata (rdata)
    );

    always_comb begin
        n_state  = r_state;
        n_col    = r_col;
        n_wl     = r_wl;
        n_sc     = r_sc;
        n_ch     = r_ch;
        n_last   = r_last;
        n_sp     = r_sp;
        n_wpre   = r_wpre;
        n_wpost  = r_wpost;
        n_nl     = r_nl;
        n_idx    = r_idx;
        n_left   = r_left;
        n_ovalid = r_ovalid && !i_out_ready;
        n_out    = r_out;

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_ch    = i_in_data.in_char;
                    n_last  = i_in_data.end_of_text;
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                n_wl    = wl_eff;
                n_sp    = sp_emit;
                n_nl    = is_nl || ins;
                n_wpre  = word_pre && (wl_eff != '0);
                n_wpost = !word_pre && r_last && (wl_eff != '0);
                n_idx   = '0;
                n_left  = LW'(sp_emit) + (word_on ? LW'(wl_eff) : LW'(0))
                        + LW'(is_nl || ins);
                if (r_last) begin
                    n_sc  = '0;
                    n_col = '0;
                end else if (is_sp) begin
                    if (commit_sp) begin
                        n_sc  = AW'(1);
                        n_col = col_sat;
                    end else if (r_sc != CAP) begin
                        n_sc = r_sc + AW'(1);
                    end
                end else if (is_nl) begin
                    n_sc  = '0;
                    n_col = '0;
                end else if (ins) begin
                    n_sc  = '0;
                    n_col = '0;
                end
                n_state = ST_NEXT;
            end
            ST_NEXT: begin
                if (r_sp != '0) begin
                    n_state = ST_SP;
                end else if (r_wpre) begin
                    n_state = ST_RD;
                end else if (r_nl) begin
                    n_state = ST_NL;
                end else if (r_wpost) begin
                    n_state = ST_RD;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_SP: begin
                if (slot_free) begin
                    n_ovalid       = 1'b1;
                    n_out.out_char = gww_pkg::CH_SPACE;
                    n_out.run_last = (r_left == LW'(1));
                    n_left         = r_left - LW'(1);
                    n_sp           = r_sp - AW'(1);
                    if (r_sp == AW'(1)) begin
                        n_state = ST_NEXT;
                    end
                end
            end
            ST_RD: begin
                n_state = ST_WO;
            end
            ST_WO: begin
                if (slot_free) begin
                    n_ovalid       = 1'b1;
                    n_out.out_char = rdata;
                    n_out.run_last = (r_left == LW'(1));
                    n_left         = r_left - LW'(1);
                    if (r_idx == r_wl - AW'(1)) begin
                        n_idx   = '0;
                        n_wl    = '0;
                        n_wpre  = 1'b0;
                        n_wpost = 1'b0;
                        n_state = ST_NEXT;
                    end else begin
                        n_idx   = r_idx + AW'(1);
                        n_state = ST_RD;
                    end
                end
            end
            ST_NL: begin
                if (slot_free) begin
                    n_ovalid       = 1'b1;
                    n_out.out_char = gww_pkg::CH_NEWLINE;
                    n_out.run_last = (r_left == LW'(1));
                    n_left         = r_left - LW'(1);
                    n_nl           = 1'b0;
                    n_state        = ST_NEXT;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_limit  <= gww_pkg::LIMIT_RESET;
            r_col    <= '0;
            r_wl     <= '0;
            r_sc     <= '0;
            r_sp     <= '0;
            r_wpre   <= 1'b0;
            r_wpost  <= 1'b0;
            r_nl     <= 1'b0;
            r_idx    <= '0;
            r_left   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_col    <= n_col;
            r_wl     <= n_wl;
            r_sc     <= n_sc;
            r_sp     <= n_sp;
            r_wpre   <= n_wpre;
            r_wpost  <= n_wpost;
            r_nl     <= n_nl;
            r_idx    <= n_idx;
            r_left   <= n_left;
            r_ovalid <= n_ovalid;
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ch   <= n_ch;
        r_last <= n_last;
        r_out  <= n_out;
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

`include "assert_macros.svh"

    `GWW_ASSERT_IMP(a_idle_none_left, r_state == ST_IDLE,
        r_left == '0 && !r_nl && r_sp == '0, "output words left over at idle")
    `GWW_ASSERT_IMP(a_counts_capped, 1'b1,
        r_wl <= CAP && r_sc <= CAP, "pending count above capacity")
    `GWW_ASSERT_NXT(a_last_clears, r_state == ST_EVAL && r_last,
        r_col == '0 && r_sc == '0, "end of text left column or spaces")
    `GWW_ASSERT_NXT(a_accept_eval, i_in_valid && o_in_ready,
        r_state == ST_EVAL, "accepted word not evaluated")

endmodule

/* hw/rtl/gww_word_buf.sv */
// Pending word store: one write port, one read port with registered data.
// Depends on nothing but its parameters.
module gww_word_buf #(
    parameter int BUF_DEPTH = 32,
    parameter int AW        = 5
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] r_mem [BUF_DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
